/* hw/rtl/next_prime_finder_top_defines.svh */
// assertion macros used by the port-level checker
`ifndef NEXT_PRIME_FINDER_TOP_DEFINES_SVH
`define NEXT_PRIME_FINDER_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define NPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("next prime finder check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define NPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next prime finder check failed");

`endif

/* hw/rtl/npf_pkg.sv */
// types, microcode table and constants for the next prime finder
package npf_pkg;

  localparam int unsigned PRIME_W = 31;
  localparam int unsigned PC_W    = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DINIT,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DNEXT,
    OP_CNEXT,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_ACCEPT,
    C_SMALL,
    C_SQ_GT,
    C_DIV_MORE,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            take;
  } ucode_t;

  typedef struct packed {
    logic low_start;
    logic sq_gt;
    logic div_more;
    logic rem_zero;
    logic out_busy;
  } stat_t;

  localparam logic [PC_W-1:0] S_FETCH = PC_W'(0);
  localparam logic [PC_W-1:0] S_CAND  = PC_W'(2);
  localparam logic [PC_W-1:0] S_BOUND = PC_W'(3);
  localparam logic [PC_W-1:0] S_DIV   = PC_W'(5);
  localparam logic [PC_W-1:0] S_NEXT  = PC_W'(8);
  localparam logic [PC_W-1:0] S_EMIT  = PC_W'(9);

  // control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_W'(0):  w = '{op: OP_LOAD,    cond: C_NOT_ACCEPT, target: S_FETCH, take: 1'b1};
      PC_W'(1):  w = '{op: OP_NONE,    cond: C_SMALL,      target: S_EMIT,  take: 1'b0};
      PC_W'(2):  w = '{op: OP_DINIT,   cond: C_NEVER,      target: S_FETCH, take: 1'b0};
      PC_W'(3):  w = '{op: OP_NONE,    cond: C_SQ_GT,      target: S_EMIT,  take: 1'b0};
      PC_W'(4):  w = '{op: OP_DIVINIT, cond: C_NEVER,      target: S_FETCH, take: 1'b0};
      PC_W'(5):  w = '{op: OP_DIVSTEP, cond: C_DIV_MORE,   target: S_DIV,   take: 1'b0};
      PC_W'(6):  w = '{op: OP_NONE,    cond: C_REM_ZERO,   target: S_NEXT,  take: 1'b0};
      PC_W'(7):  w = '{op: OP_DNEXT,   cond: C_ALWAYS,     target: S_BOUND, take: 1'b0};
      PC_W'(8):  w = '{op: OP_CNEXT,   cond: C_ALWAYS,     target: S_CAND,  take: 1'b0};
      PC_W'(9):  w = '{op: OP_EMIT,    cond: C_OUT_BUSY,   target: S_EMIT,  take: 1'b0};
      PC_W'(10): w = '{op: OP_NONE,    cond: C_ALWAYS,     target: S_FETCH, take: 1'b0};
      default:   w = '{op: OP_NONE,    cond: C_ALWAYS,     target: S_FETCH, take: 1'b0};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/npf_dp.sv */
// datapath: candidate, divisor, running square, bit-serial remainder, output register
module npf_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npf_pkg::op_e                  op_i,
  input  logic [VALUE_WIDTH-1:0]        start_value_i,
  input  logic                          out_stall_i,
  output npf_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  output logic [npf_pkg::PRIME_W-1:0]   next_prime_o
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic [W-1:0]    cand_q, cand_d;
  logic [W-1:0]    div_q, div_d;
  logic [W:0]      sq_q, sq_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            small_q, small_d;
  logic            out_valid_q, out_valid_d;
  logic [npf_pkg::PRIME_W-1:0] prime_q, prime_d;

  logic                            start_small;
  logic [W:0]                      shifted;
  logic [W+1:0]                    diff;
  logic [npf_pkg::PRIME_W+W-1:0]   cand_ext;

  // negative, or unsigned value of two or less
  assign start_small = start_value_i[W-1] | (start_value_i <= W'(2));

  // one restoring division step: bring in the next candidate bit
  assign shifted  = {rem_q, cand_q[cnt_q]};
  assign diff     = {1'b0, shifted} - {2'b00, div_q};
  assign cand_ext = {{npf_pkg::PRIME_W{1'b0}}, cand_q};

  always_comb begin
    cand_d      = cand_q;
    div_d       = div_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    small_d     = small_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q & out_stall_i;
    case (op_i)
      npf_pkg::OP_LOAD: begin
        small_d = start_small;
        cand_d  = start_small ? W'(2) : (start_value_i | W'(1));
      end
      npf_pkg::OP_DINIT: begin
        div_d = W'(3);
        sq_d  = (W + 1)'(9);
      end
      npf_pkg::OP_DIVINIT: begin
        rem_d = '0;
        cnt_d = CntW'(W - 1);
      end
      npf_pkg::OP_DIVSTEP: begin
        rem_d = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
        cnt_d = cnt_q - CntW'(1);
      end
      npf_pkg::OP_DNEXT: begin
        // (d+2)^2 = d^2 + 4d + 4
        div_d = div_q + W'(2);
        sq_d  = sq_q + {div_q[W-2:0], 2'b00} + (W + 1)'(4);
      end
      npf_pkg::OP_CNEXT: begin
        cand_d = cand_q + W'(2);
      end
      npf_pkg::OP_EMIT: begin
        out_valid_d = 1'b1;
        prime_d     = cand_ext[npf_pkg::PRIME_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    small_q <= small_d;
    prime_q <= prime_d;
  end

  assign stat_o.low_start = small_q;
  assign stat_o.sq_gt     = sq_q > {1'b0, cand_q};
  assign stat_o.div_more  = cnt_q != '0;
  assign stat_o.rem_zero  = rem_q == '0;
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign next_prime_o = prime_q;

endmodule

/* hw/rtl/npf_seq.sv */
// microcode sequencer: step counter, control store lookup, jump evaluation
module npf_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  npf_pkg::stat_t stat_i,
  output logic           in_stall_o,
  output npf_pkg::op_e   op_o
);

  logic [npf_pkg::PC_W-1:0] pc_q, pc_d;
  npf_pkg::ucode_t          uw;
  logic                     accept;
  logic                     jump;

  assign uw     = npf_pkg::ucode_rom(pc_q);
  assign accept = uw.take & in_valid_i;

  always_comb begin
    case (uw.cond)
      npf_pkg::C_NEVER:      jump = 1'b0;
      npf_pkg::C_ALWAYS:     jump = 1'b1;
      npf_pkg::C_NOT_ACCEPT: jump = !accept;
      npf_pkg::C_SMALL:      jump = stat_i.low_start;
      npf_pkg::C_SQ_GT:      jump = stat_i.sq_gt;
      npf_pkg::C_DIV_MORE:   jump = stat_i.div_more;
      npf_pkg::C_REM_ZERO:   jump = stat_i.rem_zero;
      npf_pkg::C_OUT_BUSY:   jump = stat_i.out_busy;
      default:               jump = 1'b1;
    endcase
  end

  // suppress ops whose handshake did not complete
  always_comb begin
    op_o = uw.op;
    if (uw.op == npf_pkg::OP_LOAD && !accept) begin
      op_o = npf_pkg::OP_NONE;
    end
    if (uw.op == npf_pkg::OP_EMIT && stat_i.out_busy) begin
      op_o = npf_pkg::OP_NONE;
    end
  end

  assign pc_d       = jump ? uw.target : pc_q + npf_pkg::PC_W'(1);
  assign in_stall_o = !uw.take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= npf_pkg::S_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* hw/rtl/next_prime_finder_top.sv */
// top level of the next prime finder: microcode sequencer plus trial-division datapath
// a start of two or less goes straight to the result; otherwise each candidate
//   is divided by odd divisors (up to isqrt/2 of them) in the one-bit-per-cycle
//   remainder unit, between the fetch and the result hand-off
// one transaction in flight at a time; the next is taken only after the result is registered
// reset: asynchronous, clears the step counter and the output valid flag
module next_prime_finder_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0]      start_value_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [npf_pkg::PRIME_W-1:0] next_prime_o
);

  // control word op and datapath flags between sequencer and datapath
  npf_pkg::op_e   op;
  npf_pkg::stat_t stat;

  // sequencer walks the control store: fetch, small-value bypass,
  // per-candidate bound check, bit-serial remainder loop, divisor step,
  // candidate step and result emit
  npf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .op_o       (op)
  );

  // datapath keeps the running square of the divisor so the bound check
  // is a plain compare, and holds the result in its own output register
  npf_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .start_value_i (start_value_i),
    .out_stall_i   (out_stall_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .next_prime_o  (next_prime_o)
  );

endmodule

/* hw/rtl/npf_chk.sv */
// port-level checker for the next prime finder, bound to the top level
`include "next_prime_finder_top_defines.svh"

module npf_chk #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [VALUE_WIDTH-1:0]        start_value_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [npf_pkg::PRIME_W-1:0]   next_prime_o
);

  logic in_fire;
  logic out_hold;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // one transaction at a time: input closes right after a take
  `NPF_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_fire, in_stall_o)
  // a result is two or an odd number
  `NPF_ASSERT_IMP(a_prime_shape, clk_i, rst_ni, out_valid_o,
    next_prime_o[0] || next_prime_o == npf_pkg::PRIME_W'(2))
  // a stalled result stays and keeps its value
  `NPF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_hold,
    out_valid_o && $stable(next_prime_o))
  // after a take of a start value of zero, an unstalled valid result must not be one
  `NPF_ASSERT_NXT(a_zero_start, clk_i, rst_ni, in_fire && start_value_i == '0,
    !out_valid_o || out_stall_i || next_prime_o != npf_pkg::PRIME_W'(1))

endmodule

bind next_prime_finder_top npf_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_npf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .start_value_i (start_value_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .next_prime_o  (next_prime_o)
);
